// File: design/tws_pkg.sv
// shared constants and types for the three-wire serial master
package tws_pkg;

  localparam int unsigned TickW = 10;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitIdxW = 4;
  localparam int unsigned OpW = 2;
  localparam int unsigned PhaseW = 2;

  localparam logic [TickW-1:0] HalfPeriodReset = TickW'(10);

  localparam logic [OpW-1:0] OpTick = 2'd0;
  localparam logic [OpW-1:0] OpRead = 2'd1;
  localparam logic [OpW-1:0] OpWrite = 2'd2;

  localparam logic [PhaseW-1:0] PhIdle = 2'd0;
  localparam logic [PhaseW-1:0] PhLow = 2'd1;
  localparam logic [PhaseW-1:0] PhHigh = 2'd2;

  localparam logic [BitIdxW-1:0] SecondByteIdx = 4'd8;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic [BitIdxW-1:0] bit_index;
    logic [ByteW-1:0]   shift_reg;
    logic [ByteW-1:0]   second_byte;
    logic               is_write;
    logic [TickW-1:0]   tick_count;
    logic [ByteW-1:0]   received_byte;
  } tws_state_t;

  // the master drives the data pin for the command byte and for write data
  function automatic logic sending(logic [BitIdxW-1:0] bit_index, logic is_write);
    sending = (bit_index < SecondByteIdx) || is_write;
  endfunction

endpackage

// File: design/three_wire_serial_master_core.sv
// three-wire serial master: one timing tick per input word, pin levels per output word
//
// usage:
//   the input channel carries one word per timing tick: an operation code
//   (tick, start read, start write), the command byte, the write data byte
//   and the sampled data pin level. every accepted input word yields exactly
//   one output word holding the pin levels, busy, done and the last byte read.
//   the output word is registered, valid in the cycle after input accept; a new word is
//   accepted every cycle unless the input is stalled, so the tick rate equals the clock rate
//   when neither side idles. the result register is the only stage: the input is stalled
//   only while a result is held and the receiver stalls it.
//   cfg_we_i writes the half-period register (ticks per clock half period,
//   zero acts as one); write it only while no transaction is in progress.
//   a serial bit takes two half periods, a transaction sixteen bits.
//   reset returns to idle: chip enable low, clock high, data pin released,
//   half period 10, read data zero, no output word pending.
module three_wire_serial_master_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tws_pkg::TickW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tws_pkg::OpW-1:0]      operation_i,
  input  logic [tws_pkg::ByteW-1:0]    command_i,
  input  logic [tws_pkg::ByteW-1:0]    write_data_i,
  input  logic                         io_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         chip_enable_o,
  output logic                         serial_clock_o,
  output logic                         io_out_o,
  output logic                         io_drive_o,
  output logic                         busy_res_o,
  output logic                         done_res_o,
  output logic [tws_pkg::ByteW-1:0]    read_data_o
);

  logic [tws_pkg::TickW-1:0] half_q;
  tws_pkg::tws_state_t       st_q, st_d;
  logic                      out_valid_q;
  logic                      accept;
  logic [tws_pkg::TickW-1:0] half_eff;
  logic [tws_pkg::TickW-1:0] tick_inc;
  logic                      period_end;
  logic                      done_d;
  logic                      active_d, drive_d;
  logic [tws_pkg::BitIdxW-1:0] idx_inc;

  logic ce_q, sclk_q, io_out_q, drive_q, busy_q, done_q;
  logic [tws_pkg::ByteW-1:0] rd_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept = in_valid_i && !in_stall_o;

  assign half_eff = (half_q == '0) ? tws_pkg::TickW'(1) : half_q;
  assign tick_inc = st_q.tick_count + tws_pkg::TickW'(1);
  assign period_end = tick_inc >= half_eff;
  assign idx_inc = st_q.bit_index + tws_pkg::BitIdxW'(1);

  always_comb begin
    st_d = st_q;
    done_d = 1'b0;
    unique case (st_q.phase)
      tws_pkg::PhLow: begin
        st_d.tick_count = tick_inc;
        if (period_end) begin
          st_d.tick_count = '0;
          if (!tws_pkg::sending(st_q.bit_index, st_q.is_write)) begin
            st_d.shift_reg = {io_in_i, st_q.shift_reg[tws_pkg::ByteW-1:1]};
          end
          st_d.phase = tws_pkg::PhHigh;
        end
      end
      tws_pkg::PhHigh: begin
        st_d.tick_count = tick_inc;
        if (period_end) begin
          st_d.tick_count = '0;
          if (tws_pkg::sending(st_q.bit_index, st_q.is_write)) begin
            st_d.shift_reg = {1'b0, st_q.shift_reg[tws_pkg::ByteW-1:1]};
          end
          st_d.bit_index = idx_inc;
          if (idx_inc == tws_pkg::SecondByteIdx) begin
            st_d.shift_reg = st_q.is_write ? st_q.second_byte : '0;
            st_d.phase = tws_pkg::PhLow;
          end else if (idx_inc == '0) begin
            if (!st_q.is_write) begin
              st_d.received_byte = st_d.shift_reg;
            end
            st_d.phase = tws_pkg::PhIdle;
            done_d = 1'b1;
          end else begin
            st_d.phase = tws_pkg::PhLow;
          end
        end
      end
      default: begin
        st_d.phase = tws_pkg::PhIdle;
        if (operation_i == tws_pkg::OpRead || operation_i == tws_pkg::OpWrite) begin
          st_d.phase = tws_pkg::PhLow;
          st_d.bit_index = '0;
          st_d.shift_reg = command_i;
          st_d.second_byte = write_data_i;
          st_d.is_write = (operation_i == tws_pkg::OpWrite);
          st_d.tick_count = '0;
        end
      end
    endcase
  end

  assign active_d = (st_d.phase == tws_pkg::PhLow) || (st_d.phase == tws_pkg::PhHigh);
  assign drive_d = active_d && tws_pkg::sending(st_d.bit_index, st_d.is_write);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= tws_pkg::HalfPeriodReset;
    end else if (cfg_we_i) begin
      half_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        st_q <= st_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ce_q <= 1'b0;
      sclk_q <= 1'b1;
      drive_q <= 1'b0;
      io_out_q <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rd_q <= '0;
    end else if (accept) begin
      ce_q <= active_d;
      sclk_q <= (st_d.phase != tws_pkg::PhLow);
      drive_q <= drive_d;
      io_out_q <= drive_d && st_d.shift_reg[0];
      busy_q <= active_d;
      done_q <= done_d;
      rd_q <= st_d.received_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign chip_enable_o = ce_q;
  assign serial_clock_o = sclk_q;
  assign io_out_o = io_out_q;
  assign io_drive_o = drive_q;
  assign busy_res_o = busy_q;
  assign done_res_o = done_q;
  assign read_data_o = rd_q;

  // a finished transaction leaves the link idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o && serial_clock_o && !io_drive_o)
    else $error("done word with link still active");

  // the data pin is only driven inside a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && io_drive_o |-> chip_enable_o)
    else $error("data pin driven with chip enable low");

  // idle link keeps the clock high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> serial_clock_o && !io_out_o)
    else $error("idle link with clock low or data driven");

  // input is held back only while a result word waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // a stalled result word stays in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) && $stable(busy_res_o))
    else $error("stalled result word changed");

endmodule
